// File: rtl/core/hsv_to_rgb_pwm_macros.svh
// Assertion macros for the HSV to RGB PWM converter RTL; only the queue includes them.
// Define ASSERT_OFF to compile every check out to nothing.
`ifndef HSV_TO_RGB_PWM_MACROS_SVH
`define HSV_TO_RGB_PWM_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, ck, rst_n, prop, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, ck, rst_n, expr, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, ck, rst_n, prop, msg)
`define ASSERT_NEVER(label, ck, rst_n, expr, msg)
`endif
`endif

// File: rtl/core/hsvrgb_pkg.sv
// Shared types and constants for the HSV to RGB PWM converter.
// No dependencies.
package hsvrgb_pkg;

	// hue sectors, sixty degrees each
	localparam logic [2:0] SEC_R_TO_Y = 3'd0;
	localparam logic [2:0] SEC_Y_TO_G = 3'd1;
	localparam logic [2:0] SEC_G_TO_C = 3'd2;
	localparam logic [2:0] SEC_C_TO_B = 3'd3;
	localparam logic [2:0] SEC_B_TO_M = 3'd4;
	localparam logic [2:0] SEC_M_TO_R = 3'd5;

	localparam logic [8:0] HUE_WRAP = 9'd360;
	localparam logic [8:0] DEG_60   = 9'd60;
	localparam logic [8:0] DEG_120  = 9'd120;
	localparam logic [8:0] DEG_180  = 9'd180;
	localparam logic [8:0] DEG_240  = 9'd240;
	localparam logic [8:0] DEG_300  = 9'd300;
	localparam logic [5:0] SPAN_DEG = 6'd60;

	localparam int FAC_W = 14;
	localparam logic signed [FAC_W-1:0] FAC_FULL = 14'sd6000;
	localparam logic signed [FAC_W-1:0] FAC_PCT  = 14'sd100;
	localparam logic signed [FAC_W-1:0] FAC_DEG  = 14'sd60;

	// channel numerators over 600000
	localparam int NUM_W = 21;
	localparam logic signed [NUM_W-1:0] NUM_FULL = 21'sd6000;

	localparam int PROD_W = 38;
	localparam logic signed [PROD_W-1:0] HALF_DENOM = 38'sd300000;

	// 600000 = 64 * 9375; divide by 9375 through a reciprocal of 2^44
	localparam int PRE_SHIFT = 6;
	localparam int X_W       = 30;
	localparam int RECIP_W   = 31;
	localparam int MQ_W      = X_W + RECIP_W;
	localparam int DIV_SHIFT = 44;
	localparam int Q_W       = 17;
	localparam int REM_W     = 31;
	localparam logic [RECIP_W-1:0] RECIP_9375 = 31'd1876499844;
	localparam logic [13:0]        DIV_ODD    = 14'd9375;

	localparam int DUTY_W = 16;

	typedef struct packed {
		logic [2:0]              sector;
		logic [6:0]              value;
		logic signed [FAC_W-1:0] fac_p;
		logic signed [FAC_W-1:0] fac_q;
		logic signed [FAC_W-1:0] fac_t;
	} cls_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// File: rtl/core/hsvrgb_front.sv
// Front end: accepts colour items, folds the hue into a sector and offset
// and forms the per-item channel factors. Depends on hsvrgb_pkg.
module hsvrgb_front
	import hsvrgb_pkg::*;
(
	input  logic       hsv_valid,
	output logic       hsv_stall,
	input  logic [8:0] hue,
	input  logic [6:0] saturation,
	input  logic [6:0] brightness,
	input  q_stat_t    q_stat,
	output logic       push,
	output cls_t       cls
);

	logic [8:0]  hue_w;
	logic [8:0]  base;
	logic [5:0]  rem_deg;
	logic [5:0]  rest_deg;
	logic [12:0] s_rem;
	logic [12:0] s_rest;
	logic [2:0]  sector;

	assign hsv_stall = q_stat.full;
	assign push      = hsv_valid && !q_stat.full;

	always_comb begin
		hue_w = (hue >= HUE_WRAP) ? '0 : hue;
		if (hue_w >= DEG_300) begin
			sector = SEC_M_TO_R;
			base   = DEG_300;
		end else if (hue_w >= DEG_240) begin
			sector = SEC_B_TO_M;
			base   = DEG_240;
		end else if (hue_w >= DEG_180) begin
			sector = SEC_C_TO_B;
			base   = DEG_180;
		end else if (hue_w >= DEG_120) begin
			sector = SEC_G_TO_C;
			base   = DEG_120;
		end else if (hue_w >= DEG_60) begin
			sector = SEC_Y_TO_G;
			base   = DEG_60;
		end else begin
			sector = SEC_R_TO_Y;
			base   = '0;
		end
		rem_deg  = 6'(hue_w - base);
		rest_deg = SPAN_DEG - rem_deg;
		s_rem    = {6'b0, saturation} * {7'b0, rem_deg};
		s_rest   = {6'b0, saturation} * {7'b0, rest_deg};
	end

	always_comb begin
		cls.sector = sector;
		cls.value  = brightness;
		cls.fac_p  = (FAC_PCT - signed'({7'b0, saturation})) * FAC_DEG;
		cls.fac_q  = FAC_FULL - signed'({1'b0, s_rem});
		cls.fac_t  = FAC_FULL - signed'({1'b0, s_rest});
	end

endmodule

// File: rtl/core/hsvrgb_queue.sv
// Short register queue of classified items between front and back end.
// Depends on hsvrgb_pkg and the assertion macro header.
`include "hsv_to_rgb_pwm_macros.svh"
module hsvrgb_queue
	import hsvrgb_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cls_t    din,
	input  logic    pop,
	output cls_t    head,
	output q_stat_t q_stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cls_t          ent_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign head         = ent_q[rd_ptr_q];
	assign q_stat.full  = (cnt_q == CW'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	`ASSERT_NEVER(a_cnt_bound, clk, arst_n, cnt_q > CW'(DEPTH), "queue count above depth")
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && q_stat.empty, "pop from empty queue")
	`ASSERT_ALWAYS(a_cnt_up, clk, arst_n, (push && !pop) |=> (cnt_q == $past(cnt_q) + CW'(1)), "queue count lost a push")

endmodule

// File: rtl/core/hsvrgb_scale.sv
// One channel scaler: numerator times full-scale count, rounded division
// by 600000 via reciprocal multiply and correction. Depends on hsvrgb_pkg.
module hsvrgb_scale
	import hsvrgb_pkg::*;
(
	input  logic                    clk,
	input  logic                    adv,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DUTY_W-1:0]       top,
	output logic [Q_W-1:0]          quo,
	output logic                    neg
);

	logic signed [PROD_W-1:0] num_x;
	logic signed [PROD_W-1:0] top_x;
	logic signed [PROD_W-1:0] prod_s2;
	logic [X_W-1:0]           x_w;
	logic [MQ_W-1:0]          mq_w;
	logic [X_W-1:0]           x_s3;
	logic [Q_W-1:0]           q_s3;
	logic                     neg_s3;
	logic [REM_W-1:0]         rem_w;
	logic [Q_W-1:0]           q_s4;
	logic                     neg_s4;

	assign num_x = PROD_W'(num);
	assign top_x = signed'({{(PROD_W - DUTY_W){1'b0}}, top});
	assign x_w   = prod_s2[X_W+PRE_SHIFT-1:PRE_SHIFT];
	assign mq_w  = {{RECIP_W{1'b0}}, x_w} * {{X_W{1'b0}}, RECIP_9375};
	// estimate is at most one short
	assign rem_w = {1'b0, x_s3} - REM_W'({14'b0, q_s3} * {17'b0, DIV_ODD});

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= num_x * top_x + HALF_DENOM;
			neg_s3  <= prod_s2[PROD_W-1];
			x_s3    <= x_w;
			q_s3    <= mq_w[MQ_W-1:DIV_SHIFT];
			neg_s4  <= neg_s3;
			q_s4    <= q_s3 + Q_W'(rem_w >= REM_W'(DIV_ODD));
		end
	end

	assign quo = q_s4;
	assign neg = neg_s4;

endmodule

// File: rtl/core/hsvrgb_back.sv
// Back end: pops classified items, forms the channel numerators, scales
// them and holds the result for the output. Depends on hsvrgb_pkg, hsvrgb_scale.
module hsvrgb_back
	import hsvrgb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cls_t              head,
	input  q_stat_t           q_stat,
	output logic              pop,
	input  logic [DUTY_W-1:0] pwm_top,
	output logic              rgb_valid,
	input  logic              rgb_stall,
	output logic [DUTY_W-1:0] red_duty,
	output logic [DUTY_W-1:0] green_duty,
	output logic [DUTY_W-1:0] blue_duty
);

	logic                    adv;
	logic                    v_s1, v_s2, v_s3, v_s4;
	logic                    rgb_valid_q;
	logic signed [NUM_W-1:0] v_x, nv, np, nq, nt;
	logic signed [NUM_W-1:0] red_num_s1, green_num_s1, blue_num_s1;
	logic [Q_W-1:0]          red_q4, green_q4, blue_q4;
	logic                    red_neg, green_neg, blue_neg;
	logic [DUTY_W-1:0]       red_q, green_q, blue_q;

	// whole pipe moves unless a finished result is held
	assign adv = !rgb_valid_q || !rgb_stall;
	assign pop = adv && !q_stat.empty;

	assign v_x = signed'({{(NUM_W - 7){1'b0}}, head.value});
	assign nv  = v_x * NUM_FULL;
	assign np  = v_x * NUM_W'(head.fac_p);
	assign nq  = v_x * NUM_W'(head.fac_q);
	assign nt  = v_x * NUM_W'(head.fac_t);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			rgb_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= pop;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			rgb_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			unique case (head.sector)
				SEC_R_TO_Y: begin
					red_num_s1 <= nv; green_num_s1 <= nt; blue_num_s1 <= np;
				end
				SEC_Y_TO_G: begin
					red_num_s1 <= nq; green_num_s1 <= nv; blue_num_s1 <= np;
				end
				SEC_G_TO_C: begin
					red_num_s1 <= np; green_num_s1 <= nv; blue_num_s1 <= nt;
				end
				SEC_C_TO_B: begin
					red_num_s1 <= np; green_num_s1 <= nq; blue_num_s1 <= nv;
				end
				SEC_B_TO_M: begin
					red_num_s1 <= nt; green_num_s1 <= np; blue_num_s1 <= nv;
				end
				default: begin
					red_num_s1 <= nv; green_num_s1 <= np; blue_num_s1 <= nq;
				end
			endcase
		end
	end

	hsvrgb_scale u_scale_red (
		.clk (clk), .adv (adv), .num (red_num_s1), .top (pwm_top),
		.quo (red_q4), .neg (red_neg)
	);

	hsvrgb_scale u_scale_green (
		.clk (clk), .adv (adv), .num (green_num_s1), .top (pwm_top),
		.quo (green_q4), .neg (green_neg)
	);

	hsvrgb_scale u_scale_blue (
		.clk (clk), .adv (adv), .num (blue_num_s1), .top (pwm_top),
		.quo (blue_q4), .neg (blue_neg)
	);

	function automatic logic [DUTY_W-1:0] clamp_duty(
		input logic [Q_W-1:0]    q,
		input logic              n,
		input logic [DUTY_W-1:0] t
	);
		logic [DUTY_W-1:0] d;
		if (n) begin
			d = '0;
		end else if (q > {1'b0, t}) begin
			d = t;
		end else begin
			d = q[DUTY_W-1:0];
		end
		return d;
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			red_q   <= clamp_duty(red_q4, red_neg, pwm_top);
			green_q <= clamp_duty(green_q4, green_neg, pwm_top);
			blue_q  <= clamp_duty(blue_q4, blue_neg, pwm_top);
		end
	end

	assign rgb_valid  = rgb_valid_q;
	assign red_duty   = red_q;
	assign green_duty = green_q;
	assign blue_duty  = blue_q;

endmodule

// File: rtl/core/hsv_to_rgb_pwm.sv
// HSV to RGB PWM duty converter, top level.
// Path: queue, numerator registers, scaler product, estimate and quotient registers, duty registers.
// Throughput: one item per cycle while the output is not stalled; the scaling pipe of the back end sets it.
// The queue holds QUEUE_DEPTH items so input and output stall independently.
// Reset empties the queue and pipe and sets pwm_top to 255.
module hsv_to_rgb_pwm
	import hsvrgb_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [DUTY_W-1:0] cfg_wdata,
	input  logic              hsv_valid,
	output logic              hsv_stall,
	input  logic [8:0]        hue,
	input  logic [6:0]        saturation,
	input  logic [6:0]        brightness,
	output logic              rgb_valid,
	input  logic              rgb_stall,
	output logic [DUTY_W-1:0] red_duty,
	output logic [DUTY_W-1:0] green_duty,
	output logic [DUTY_W-1:0] blue_duty
);

	logic [DUTY_W-1:0] pwm_top_q;
	logic              push;
	logic              pop;
	cls_t              cls;
	cls_t              head;
	q_stat_t           q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_top_q <= 16'd255;
		end else if (cfg_wen) begin
			pwm_top_q <= cfg_wdata;
		end
	end

	hsvrgb_front u_front (
		.hsv_valid  (hsv_valid),
		.hsv_stall  (hsv_stall),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.q_stat     (q_stat),
		.push       (push),
		.cls        (cls)
	);

	hsvrgb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cls),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	hsvrgb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.pwm_top    (pwm_top_q),
		.rgb_valid  (rgb_valid),
		.rgb_stall  (rgb_stall),
		.red_duty   (red_duty),
		.green_duty (green_duty),
		.blue_duty  (blue_duty)
	);

endmodule

// File: tb/sv/tb.sv
// Testbench for hsv_to_rgb_pwm: random and directed colors with a local duty predictor.
// Depends on hsvrgb_pkg and the hsv_to_rgb_pwm RTL; needs no other files.
`timescale 1ns / 1ps

module tb;
	import hsvrgb_pkg::*;

	localparam longint DUTY_DENOM = 600000;
	localparam longint DUTY_HALF  = 300000;

	typedef struct packed {
		logic [DUTY_W-1:0] red;
		logic [DUTY_W-1:0] green;
		logic [DUTY_W-1:0] blue;
	} duty_set_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wen = 1'b0;
	logic [DUTY_W-1:0] cfg_wdata = '0;
	logic              hsv_valid = 1'b0;
	logic              hsv_stall;
	logic [8:0]        hue = '0;
	logic [6:0]        saturation = '0;
	logic [6:0]        brightness = '0;
	logic              rgb_valid;
	logic              rgb_stall = 1'b0;
	logic [DUTY_W-1:0] red_duty;
	logic [DUTY_W-1:0] green_duty;
	logic [DUTY_W-1:0] blue_duty;

	duty_set_t         pending_duty[$];
	logic [DUTY_W-1:0] pwm_top_copy = 16'd255;
	int                mismatch_count = 0;
	bit                quiet = 1'b0;
	int                hold_left = 0;

	hsv_to_rgb_pwm dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.hsv_valid  (hsv_valid),
		.hsv_stall  (hsv_stall),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.rgb_valid  (rgb_valid),
		.rgb_stall  (rgb_stall),
		.red_duty   (red_duty),
		.green_duty (green_duty),
		.blue_duty  (blue_duty)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [DUTY_W-1:0] scale_duty(longint num, longint top);
		longint prod;
		longint duty;
		prod = num * top + DUTY_HALF;
		if (prod < 0)
			return '0;
		duty = prod / DUTY_DENOM;
		if (duty > top)
			duty = top;
		return duty[DUTY_W-1:0];
	endfunction

	function automatic duty_set_t predict_duty(logic [8:0] h, logic [6:0] s, logic [6:0] v);
		longint    deg, sat, val, rem;
		longint    n_v, n_p, n_q, n_t;
		longint    n_r, n_g, n_b;
		logic [2:0] sec;
		duty_set_t d;
		deg = (h >= HUE_WRAP) ? 0 : longint'(h);
		sat = longint'(s);
		val = longint'(v);
		sec = 3'(deg / longint'(DEG_60));
		rem = deg % longint'(DEG_60);
		n_v = val * 6000;
		n_p = val * (100 - sat) * 60;
		n_q = val * (6000 - sat * rem);
		n_t = val * (6000 - sat * (60 - rem));
		case (sec)
			SEC_R_TO_Y: begin n_r = n_v; n_g = n_t; n_b = n_p; end
			SEC_Y_TO_G: begin n_r = n_q; n_g = n_v; n_b = n_p; end
			SEC_G_TO_C: begin n_r = n_p; n_g = n_v; n_b = n_t; end
			SEC_C_TO_B: begin n_r = n_p; n_g = n_q; n_b = n_v; end
			SEC_B_TO_M: begin n_r = n_t; n_g = n_p; n_b = n_v; end
			default: begin n_r = n_v; n_g = n_p; n_b = n_q; end
		endcase
		d.red   = scale_duty(n_r, longint'(pwm_top_copy));
		d.green = scale_duty(n_g, longint'(pwm_top_copy));
		d.blue  = scale_duty(n_b, longint'(pwm_top_copy));
		return d;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (quiet)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	task automatic send_color(input logic [8:0] h, input logic [6:0] s, input logic [6:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			hsv_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hsv_valid  <= 1'b1;
		hue        <= h;
		saturation <= s;
		brightness <= v;
		do @(posedge clk); while (hsv_stall);
		pending_duty.push_back(predict_duty(h, s, v));
	endtask

	task automatic wait_results_done();
		hsv_valid <= 1'b0;
		while (pending_duty.size() != 0)
			@(posedge clk);
		// let the pipe settle before touching the register
		repeat (8) @(posedge clk);
	endtask

	task automatic write_pwm_top(input logic [DUTY_W-1:0] top);
		wait_results_done();
		cfg_wen   <= 1'b1;
		cfg_wdata <= top;
		@(posedge clk);
		cfg_wen <= 1'b0;
		pwm_top_copy = top;
	endtask

	task automatic random_colors(input int count);
		logic [8:0] h;
		logic [6:0] s, v;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) != 0) begin
				h = 9'($urandom_range(0, 359));
				s = 7'($urandom_range(0, 100));
				v = 7'($urandom_range(0, 100));
			end else begin
				h = 9'($urandom_range(0, 511));
				s = 7'($urandom_range(0, 127));
				v = 7'($urandom_range(0, 127));
			end
			send_color(h, s, v);
		end
	endtask

	task automatic test_directed();
		// sector edges at full color
		send_color(9'd0, 7'd100, 7'd100);
		send_color(9'd59, 7'd100, 7'd100);
		send_color(9'd60, 7'd100, 7'd100);
		send_color(9'd119, 7'd100, 7'd100);
		send_color(9'd120, 7'd100, 7'd100);
		send_color(9'd180, 7'd100, 7'd100);
		send_color(9'd240, 7'd100, 7'd100);
		send_color(9'd300, 7'd100, 7'd100);
		send_color(9'd359, 7'd100, 7'd100);
		// hue wrap
		send_color(9'd360, 7'd100, 7'd100);
		send_color(9'd511, 7'd50, 7'd75);
		// grey
		send_color(9'd200, 7'd0, 7'd50);
		send_color(9'd0, 7'd0, 7'd100);
		send_color(9'd0, 7'd0, 7'd0);
		// saturation past full: negative channels clamp to zero
		send_color(9'd90, 7'd127, 7'd100);
		send_color(9'd330, 7'd127, 7'd127);
		// brightness past full: clamp to top
		send_color(9'd30, 7'd20, 7'd127);
		send_color(9'd270, 7'd0, 7'd127);
		send_color(9'd150, 7'd33, 7'd67);
		send_color(9'd210, 7'd1, 7'd1);
		send_color(9'd455, 7'd85, 7'd42);
	endtask

	task automatic test_top_settings();
		logic [DUTY_W-1:0] tops[6];
		tops = '{16'd1, 16'd65535, 16'd0, 16'd2, 16'd1000, 16'd255};
		foreach (tops[i]) begin
			write_pwm_top(tops[i]);
			random_colors(60);
		end
		for (int i = 0; i < 3; i++) begin
			write_pwm_top(DUTY_W'($urandom_range(2, 65534)));
			random_colors(90);
		end
	endtask

	task automatic test_output_hold();
		quiet = 1'b1;
		hold_left = 80;
		random_colors(40);
		quiet = 1'b0;
	endtask

	task automatic test_sender_pause();
		random_colors(25);
		hsv_valid <= 1'b0;
		while (pending_duty.size() != 0)
			@(posedge clk);
		random_colors(25);
	endtask

	task automatic test_no_idle();
		quiet = 1'b1;
		random_colors(100);
		quiet = 1'b0;
	endtask

	// result side: random stall bursts, forced hold when asked
	initial begin
		int burst;
		int roll;
		burst = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rgb_stall <= 1'b1;
				hold_left--;
			end else if (quiet) begin
				rgb_stall <= 1'b0;
			end else if (burst > 0) begin
				rgb_stall <= 1'b1;
				burst--;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 70) begin
					rgb_stall <= 1'b0;
				end else if (roll < 95) begin
					rgb_stall <= 1'b1;
					burst = $urandom_range(0, 2);
				end else begin
					rgb_stall <= 1'b1;
					burst = $urandom_range(9, 39);
				end
			end
		end
	end

	// compare each accepted result with the oldest prediction
	initial begin
		duty_set_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rgb_valid && !rgb_stall) begin
				if (pending_duty.size() == 0) begin
					$error("unexpected result: red %0d green %0d blue %0d",
						red_duty, green_duty, blue_duty);
					mismatch_count++;
				end else begin
					want = pending_duty.pop_front();
					if (red_duty !== want.red) begin
						$error("red_duty: expected %0d, got %0d", want.red, red_duty);
						mismatch_count++;
					end
					if (green_duty !== want.green) begin
						$error("green_duty: expected %0d, got %0d", want.green, green_duty);
						mismatch_count++;
					end
					if (blue_duty !== want.blue) begin
						$error("blue_duty: expected %0d, got %0d", want.blue, blue_duty);
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_output_hold();
		test_sender_pause();
		test_no_idle();
		test_top_settings();
		wait_results_done();
		repeat (12) @(posedge clk);
		if (mismatch_count == 0 && pending_duty.size() == 0)
			$display("[hsv_to_rgb_pwm] OK");
		else
			$display("[hsv_to_rgb_pwm] ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("[hsv_to_rgb_pwm] ERROR");
		$finish;
	end

endmodule
